FILE: hw/rtl/pfw_pkg.sv
`default_nettype none

package pfw_pkg;

	localparam int COORD_W    = 10;
	localparam int PIX_W      = 8;
	localparam int HEIGHT_W   = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam int CANVAS_WIDTH_DEF      = 1024;
	localparam int MAX_CANVAS_HEIGHT_DEF = 1024;

	// ramp numerator (x-left)*255 and its quotient by the span
	localparam int NUM_W      = COORD_W + PIX_W;
	localparam int QUO_W      = PIX_W;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;

	localparam int WHITE      = 255;
	localparam int SMOOTH_NUM = 765;
	localparam int SMOOTH_RND = 32512;
	localparam int SMOOTH_DEN = 65025;
	localparam int BLEND_RND  = 127;
	localparam int LUT_DEPTH  = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT   = 3'd0,
		REG_RIGHT  = 3'd1,
		REG_TOP    = 3'd2,
		REG_BOTTOM = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

	// fade rectangle after clamping to the canvas
	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] span;
		logic               nonempty;
	} region_t;

	// per-beat data that rides alongside the divider
	typedef struct packed {
		logic             hit;
		logic [PIX_W-1:0] pix;
	} side_t;

	typedef logic [PIX_W-1:0] smooth_lut_t [LUT_DEPTH];

	function automatic smooth_lut_t build_smooth_lut();
		smooth_lut_t lut;
		int          n;
		for (int t = 0; t < LUT_DEPTH; t++) begin
			n = t * t * (SMOOTH_NUM - 2 * t) + SMOOTH_RND;
			lut[t] = PIX_W'(n / SMOOTH_DEN);
		end
		return lut;
	endfunction

	localparam smooth_lut_t SMOOTH_LUT = build_smooth_lut();

endpackage

`default_nettype wire

FILE: hw/rtl/pfw_cfg.sv
`default_nettype none

module pfw_cfg #(
	parameter int CANVAS_WIDTH      = pfw_pkg::CANVAS_WIDTH_DEF,
	parameter int MAX_CANVAS_HEIGHT = pfw_pkg::MAX_CANVAS_HEIGHT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pfw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfw_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pfw_pkg::region_t                      region
);

	localparam int CW = pfw_pkg::COORD_W;
	localparam int HW = pfw_pkg::HEIGHT_W;

	logic [CW-1:0] left_q, right_q, top_q, bottom_q;
	logic [HW-1:0] height_q;
	pfw_pkg::region_t region_q;

	logic [HW-1:0] h_sat, h_m1;
	logic [CW-1:0] left_c, right_c, top_c, bottom_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			height_q <= HW'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				pfw_pkg::REG_LEFT:   left_q   <= cfg_data[CW-1:0];
				pfw_pkg::REG_RIGHT:  right_q  <= cfg_data[CW-1:0];
				pfw_pkg::REG_TOP:    top_q    <= cfg_data[CW-1:0];
				pfw_pkg::REG_BOTTOM: bottom_q <= cfg_data[CW-1:0];
				pfw_pkg::REG_HEIGHT: height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (height_q == '0)
			h_sat = HW'(1);
		else if (int'(height_q) > MAX_CANVAS_HEIGHT)
			h_sat = HW'(MAX_CANVAS_HEIGHT);
		else
			h_sat = height_q;
		h_m1 = h_sat - HW'(1);

		left_c   = (int'(left_q) > CANVAS_WIDTH - 1) ? CW'(CANVAS_WIDTH - 1) : left_q;
		right_c  = (int'(right_q) > CANVAS_WIDTH - 1) ? CW'(CANVAS_WIDTH - 1) : right_q;
		top_c    = (HW'(top_q) > h_m1) ? h_m1[CW-1:0] : top_q;
		bottom_c = (HW'(bottom_q) > h_m1) ? h_m1[CW-1:0] : bottom_q;
	end

	// registered from the clamped cfg registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else begin
			region_q.left     <= left_c;
			region_q.right    <= right_c;
			region_q.top      <= top_c;
			region_q.bottom   <= bottom_c;
			region_q.span     <= right_c - left_c;
			region_q.nonempty <= (right_c > left_c) && (bottom_c >= top_c);
		end
	end

	assign region = region_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pfw_div_stage.sv
`default_nettype none

// two restoring-division steps: quotient bits FIRST_BIT and FIRST_BIT-1
module pfw_div_stage #(
	parameter int FIRST_BIT = pfw_pkg::QUO_W - 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          valid_in,
	input  wire logic [pfw_pkg::NUM_W-1:0]     rem_in,
	input  wire logic [pfw_pkg::QUO_W-1:0]     quo_in,
	input  wire pfw_pkg::side_t                side_in,
	input  wire logic [pfw_pkg::COORD_W-1:0]   span,
	output logic                               valid_out,
	output logic [pfw_pkg::NUM_W-1:0]          rem_out,
	output logic [pfw_pkg::QUO_W-1:0]          quo_out,
	output pfw_pkg::side_t                     side_out
);

	localparam int NW = pfw_pkg::NUM_W;

	logic [NW-1:0] rem_c;
	logic [pfw_pkg::QUO_W-1:0] quo_c;
	logic [NW-1:0] sub_c;

	logic                      valid_sk;
	logic [NW-1:0]             rem_sk;
	logic [pfw_pkg::QUO_W-1:0] quo_sk;
	pfw_pkg::side_t            side_sk;

	always_comb begin
		rem_c = rem_in;
		quo_c = quo_in;
		sub_c = '0;
		for (int k = 0; k < pfw_pkg::DIV_BITS; k++) begin
			sub_c = NW'(span) << (FIRST_BIT - k);
			if (rem_c >= sub_c) begin
				rem_c = rem_c - sub_c;
				quo_c[FIRST_BIT - k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_sk <= 1'b0;
		else if (en)
			valid_sk <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sk  <= rem_c;
			quo_sk  <= quo_c;
			side_sk <= side_in;
		end
	end

	assign valid_out = valid_sk;
	assign rem_out   = rem_sk;
	assign quo_out   = quo_sk;
	assign side_out  = side_sk;

endmodule

`default_nettype wire

FILE: hw/rtl/pfw_blend.sv
`default_nettype none

// smoothstep lookup, blend multiply, divide by 255 and output register
module pfw_blend (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        valid_in,
	input  wire logic [pfw_pkg::QUO_W-1:0]   ramp,
	input  wire pfw_pkg::side_t              side_in,
	output logic                             valid_out,
	output logic [pfw_pkg::PIX_W-1:0]        pixel_out,
	output logic                             in_region
);

	localparam int PW = pfw_pkg::PIX_W;
	localparam int BW = 2 * PW + 1;

	logic           valid_s7, valid_s8, valid_s9;
	logic [PW-1:0]  fade_s7;
	pfw_pkg::side_t side_s7, side_s8;
	logic [BW-1:0]  blend_s8;
	logic [PW-1:0]  pixel_s9;
	logic           inside_s9;

	logic [BW-1:0]  q0_c, r_c;
	logic [PW-1:0]  q_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_in;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// x/256 undershoots x/255 by less than one, so one correction step is enough
	always_comb begin
		q0_c = blend_s8 >> PW;
		r_c  = blend_s8 - (q0_c << PW) + q0_c;
		q_c  = q0_c[PW-1:0] + PW'(r_c >= BW'(pfw_pkg::WHITE));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fade_s7   <= pfw_pkg::SMOOTH_LUT[ramp];
			side_s7   <= side_in;
			blend_s8  <= (BW'(pfw_pkg::WHITE) - BW'(side_s7.pix)) * BW'(fade_s7)
				+ BW'(pfw_pkg::BLEND_RND);
			side_s8   <= side_s7;
			pixel_s9  <= side_s8.hit ? side_s8.pix + q_c : side_s8.pix;
			inside_s9 <= side_s8.hit;
		end
	end

	assign valid_out = valid_s9;
	assign pixel_out = pixel_s9;
	assign in_region = inside_s9;

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_fade_to_white.sv
`default_nettype none

// channel  signals                                    dir  content
// pix      pix_valid/pix_ready                        in   pixel_x, pixel_y, pixel_in
// res      res_valid/res_ready                        out  pixel_out, in_region
// cfg      cfg_valid/cfg_ready                        in   cfg_index, cfg_data
//
// Nine register stages: input, region test and ramp numerator, four divider
// stages of two quotient bits each, smoothstep lookup, blend multiply, output.
// One beat per cycle while the pipe advances; res_valid is the output stage's valid bit.
// The whole pipe advances when res_ready is high or the output stage is empty;
// pix_ready follows that, so a stall holds every stage in place.
// Async reset clears the valid bits and the cfg registers to their reset values;
// the data registers are not reset. The clamped region is registered from
// the cfg registers after each cfg write; cfg_ready is always high.
module pixel_fade_to_white #(
	parameter int CANVAS_WIDTH      = pfw_pkg::CANVAS_WIDTH_DEF,
	parameter int MAX_CANVAS_HEIGHT = pfw_pkg::MAX_CANVAS_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	output logic                                 pix_ready,
	input  wire logic [pfw_pkg::COORD_W-1:0]     pixel_x,
	input  wire logic [pfw_pkg::COORD_W-1:0]     pixel_y,
	input  wire logic [pfw_pkg::PIX_W-1:0]       pixel_in,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output logic [pfw_pkg::PIX_W-1:0]            pixel_out,
	output logic                                 in_region,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pfw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfw_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = pfw_pkg::COORD_W;
	localparam int NW = pfw_pkg::NUM_W;
	localparam int QW = pfw_pkg::QUO_W;
	localparam int NS = pfw_pkg::DIV_STAGES;

	pfw_pkg::region_t region;
	logic en;

	logic                          valid_s1, valid_s2;
	logic [CW-1:0]                 x_s1, y_s1;
	logic [pfw_pkg::PIX_W-1:0]     p_s1;
	logic [NW-1:0]                 num_s2;
	pfw_pkg::side_t                side_s2;

	logic [CW-1:0] dx_c;
	logic          inside_c;

	logic                 div_valid [NS+1];
	logic [NW-1:0]        div_rem   [NS+1];
	logic [QW-1:0]        div_quo   [NS+1];
	pfw_pkg::side_t       div_side  [NS+1];

	pfw_cfg #(
		.CANVAS_WIDTH      (CANVAS_WIDTH),
		.MAX_CANVAS_HEIGHT (MAX_CANVAS_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.region    (region)
	);

	assign en        = res_ready | ~res_valid;
	assign pix_ready = en;

	always_comb begin
		inside_c = region.nonempty
			&& (x_s1 >= region.left) && (x_s1 <= region.right)
			&& (y_s1 >= region.top) && (y_s1 <= region.bottom);
		dx_c = x_s1 - region.left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1        <= pixel_x;
			y_s1        <= pixel_y;
			p_s1        <= pixel_in;
			// (x-left)*255
			num_s2      <= (NW'(dx_c) << pfw_pkg::PIX_W) - NW'(dx_c);
			side_s2.hit <= inside_c;
			side_s2.pix <= p_s1;
		end
	end

	assign div_valid[0] = valid_s2;
	assign div_rem[0]   = num_s2;
	assign div_quo[0]   = '0;
	assign div_side[0]  = side_s2;

	for (genvar g = 0; g < NS; g++) begin : g_div
		pfw_div_stage #(
			.FIRST_BIT (QW - 1 - g * pfw_pkg::DIV_BITS)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (div_valid[g]),
			.rem_in    (div_rem[g]),
			.quo_in    (div_quo[g]),
			.side_in   (div_side[g]),
			.span      (region.span),
			.valid_out (div_valid[g+1]),
			.rem_out   (div_rem[g+1]),
			.quo_out   (div_quo[g+1]),
			.side_out  (div_side[g+1])
		);
	end

	pfw_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (div_valid[NS]),
		.ramp      (div_quo[NS]),
		.side_in   (div_side[NS]),
		.valid_out (res_valid),
		.pixel_out (pixel_out),
		.in_region (in_region)
	);

endmodule

`default_nettype wire

FILE: verif/pfw_fade_checker.sv
module pfw_fade_checker #(
	parameter int CANVAS_WIDTH      = pfw_pkg::CANVAS_WIDTH_DEF,
	parameter int MAX_CANVAS_HEIGHT = pfw_pkg::MAX_CANVAS_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	input  logic                               pix_ready,
	input  logic [pfw_pkg::COORD_W-1:0]        pixel_x,
	input  logic [pfw_pkg::COORD_W-1:0]        pixel_y,
	input  logic [pfw_pkg::PIX_W-1:0]          pixel_in,
	input  logic                               res_valid,
	input  logic                               res_ready,
	input  logic [pfw_pkg::PIX_W-1:0]          pixel_out,
	input  logic                               in_region,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [pfw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfw_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                 outstanding,
	output int                                 fail_count
);

	localparam int PW    = pfw_pkg::PIX_W;
	localparam int CW    = pfw_pkg::COORD_W;
	localparam int WHITE = pfw_pkg::WHITE;

	typedef struct packed {
		logic [PW-1:0] pixel_out;
		logic          in_region;
	} fade_t;

	fade_t faded_q[$];

	// shadow of the region registers, raw as written
	int left_q;
	int right_q;
	int top_q;
	int bottom_q;
	int height_q;
	int errs;

	assign fail_count = errs;

	initial errs = 0;

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic fade_t fade_pixel(int x, int y, int p);
		int    h;
		int    lft;
		int    rgt;
		int    top_c;
		int    bot_c;
		int    t;
		int    f;
		int    q;
		bit    ins;
		fade_t r;
		h     = clip(height_q, 1, MAX_CANVAS_HEIGHT);
		lft   = clip(left_q, 0, CANVAS_WIDTH - 1);
		rgt   = clip(right_q, 0, CANVAS_WIDTH - 1);
		top_c = clip(top_q, 0, h - 1);
		bot_c = clip(bottom_q, 0, h - 1);
		ins   = (rgt > lft) && (bot_c >= top_c) && x >= lft && x <= rgt &&
			y >= top_c && y <= bot_c;
		q = p;
		if (ins) begin
			t = ((x - lft) * WHITE) / (rgt - lft);
			f = (t * t * (pfw_pkg::SMOOTH_NUM - 2 * t) + pfw_pkg::SMOOTH_RND) /
				pfw_pkg::SMOOTH_DEN;
			q = p + ((WHITE - p) * f + pfw_pkg::BLEND_RND) / WHITE;
		end
		r.pixel_out = q[PW-1:0];
		r.in_region = ins;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fade_t want;
		if (!arst_n) begin
			left_q   = 0;
			right_q  = 0;
			top_q    = 0;
			bottom_q = 0;
			height_q = 1024;
			faded_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pfw_pkg::REG_LEFT:   left_q   = int'(cfg_data[CW-1:0]);
					pfw_pkg::REG_RIGHT:  right_q  = int'(cfg_data[CW-1:0]);
					pfw_pkg::REG_TOP:    top_q    = int'(cfg_data[CW-1:0]);
					pfw_pkg::REG_BOTTOM: bottom_q = int'(cfg_data[CW-1:0]);
					pfw_pkg::REG_HEIGHT: height_q = int'(cfg_data);
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				faded_q.push_back(fade_pixel(int'(pixel_x), int'(pixel_y), int'(pixel_in)));
			if (res_valid && res_ready) begin
				if (faded_q.size() == 0) begin
					errs++;
					$display("%0t: result beat with none pending: pixel_out %0d in_region %0b",
						$time, pixel_out, in_region);
				end else begin
					want = faded_q.pop_front();
					if (pixel_out !== want.pixel_out) begin
						errs++;
						$display("%0t: pixel_out expected %0d actual %0d", $time,
							want.pixel_out, pixel_out);
					end
					if (in_region !== want.in_region) begin
						errs++;
						$display("%0t: in_region expected %0b actual %0b", $time,
							want.in_region, in_region);
					end
				end
			end
			outstanding <= faded_q.size();
		end
	end

endmodule

FILE: verif/tb_pixel_fade_to_white.sv
module tb_pixel_fade_to_white;

	localparam int CW = pfw_pkg::COORD_W;
	localparam int PW = pfw_pkg::PIX_W;
	localparam int IW = pfw_pkg::CFG_IDX_W;
	localparam int DW = pfw_pkg::CFG_DATA_W;

	localparam int LATENCY    = 9;
	localparam int ITEMS      = 1850;
	localparam int LONG_HOLD  = 300;
	localparam int IDLE_LIMIT = 2000;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          pix_valid = 1'b0;
	logic          pix_ready;
	logic [CW-1:0] pixel_x   = '0;
	logic [CW-1:0] pixel_y   = '0;
	logic [PW-1:0] pixel_in  = '0;
	logic          res_valid;
	logic          res_ready = 1'b0;
	logic [PW-1:0] pixel_out;
	logic          in_region;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data  = '0;

	int outstanding;
	int fail_count;
	int sent    = 0;
	int pix_run = 0;
	int res_run = 0;
	bit long_hold = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pixel_fade_to_white dut (.*);

	pfw_fade_checker fade_chk (.*);

	// per-beat wait, with occasional runs of back-to-back beats
	task automatic draw_idle(inout int run, output int cycles);
		if (run > 0) begin
			run--;
			cycles = 0;
		end else if ($urandom_range(0, 9) == 0) begin
			run    = $urandom_range(10, 40);
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, 10);
		end
	endtask

	task automatic send_pixel(input int x, input int y, input int p);
		int gap;
		draw_idle(pix_run, gap);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_x   <= CW'(x);
		pixel_y   <= CW'(y);
		pixel_in  <= PW'(p);
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		sent++;
	endtask

	// only written with the pipe drained
	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
		int gap;
		pix_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		gap = $urandom_range(0, 10);
		repeat (gap) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// bit 10 of the 10-bit registers is junk that must be dropped
	function automatic logic [DW-1:0] coord_word(int v);
		return {1'($urandom_range(0, 1)), CW'(v)};
	endfunction

	task automatic write_region(input int l, input int r, input int t, input int b,
			input int h);
		write_reg(pfw_pkg::REG_LEFT, coord_word(l));
		write_reg(pfw_pkg::REG_RIGHT, coord_word(r));
		write_reg(pfw_pkg::REG_TOP, coord_word(t));
		write_reg(pfw_pkg::REG_BOTTOM, coord_word(b));
		write_reg(pfw_pkg::REG_HEIGHT, DW'(h));
	endtask

	initial begin : result_side
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				stall = LONG_HOLD;
			end else begin
				draw_idle(res_run, stall);
			end
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (res_valid && res_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[pixel_fade_to_white] ERROR");
		$finish;
	end

	initial begin : stimulus
		int lft;
		int rgt;
		int top_r;
		int bot_r;
		int hgt;
		int heff;
		int mode;
		int phase_len;
		int x;
		int y;
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// region empty out of reset
		send_pixel(0, 0, 0);
		send_pixel(512, 300, 77);

		// whole canvas
		write_region(0, 1023, 0, 1023, 1024);
		send_pixel(0, 0, 0);
		send_pixel(1023, 1023, 0);
		send_pixel(1023, 0, 255);
		send_pixel(512, 512, 128);
		send_pixel(1, 1023, 255);
		send_pixel(0, 1023, 200);

		// one-column span, single row, height above max saturates
		write_region(100, 101, 10, 10, 2047);
		send_pixel(99, 10, 50);
		send_pixel(100, 10, 50);
		send_pixel(101, 10, 50);
		send_pixel(102, 10, 50);
		send_pixel(100, 9, 50);
		send_pixel(101, 11, 50);

		// height 0 acts as one row, rows clamp to 0
		write_reg(pfw_pkg::REG_HEIGHT, '0);
		send_pixel(100, 0, 10);
		send_pixel(101, 1, 10);

		// out-of-range index is dropped
		write_reg(IW'(pfw_pkg::REG_HEIGHT + 1), '0);
		send_pixel(101, 0, 10);

		write_reg(pfw_pkg::REG_LEFT, DW'(1024 + 5));
		send_pixel(5, 0, 33);
		send_pixel(53, 0, 33);

		// right == left is empty
		write_region(600, 600, 0, 1023, 1024);
		send_pixel(600, 0, 1);

		long_hold = 1'b1;
		while (sent < ITEMS) begin
			mode = $urandom_range(0, 9);
			top_r = $urandom_range(0, 1023);
			bot_r = $urandom_range(top_r, 1023);
			if ($urandom_range(0, 9) == 0)
				bot_r = $urandom_range(0, top_r);
			hgt = $urandom_range(0, 1) ? 1024 : $urandom_range(1, 1024);
			case (mode)
				0: begin
					lft = 0; rgt = 1023; top_r = 0; bot_r = 1023; hgt = 1024;
				end
				1: begin
					rgt = $urandom_range(0, 1023);
					lft = $urandom_range(rgt, 1023);
				end
				2: begin
					lft = $urandom_range(0, 1013);
					rgt = lft + $urandom_range(1, 10);
				end
				3: begin
					lft = $urandom_range(0, 1022);
					rgt = $urandom_range(lft + 1, 1023);
					hgt = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
				end
				default: begin
					lft = $urandom_range(0, 1022);
					rgt = $urandom_range(lft + 1, 1023);
				end
			endcase
			write_region(lft, rgt, top_r, bot_r, hgt);
			if ($urandom_range(0, 3) == 0)
				write_reg(IW'(pfw_pkg::REG_HEIGHT + $urandom_range(1, 3)),
					DW'($urandom));
			heff = hgt == 0 ? 1 : (hgt > 1024 ? 1024 : hgt);

			phase_len = $urandom_range(40, 120);
			for (int i = 0; i < phase_len && sent < ITEMS; i++) begin
				case ($urandom_range(0, 7))
					0: begin
						x = $urandom_range(0, 1023);
						y = $urandom_range(0, 1023);
					end
					1: begin
						case ($urandom_range(0, 3))
							0: x = lft;
							1: x = rgt;
							2: x = lft - 1;
							default: x = rgt + 1;
						endcase
						x = x & 1023;
						y = $urandom_range(top_r, bot_r < heff ? bot_r : heff - 1);
					end
					default: begin
						x = $urandom_range(lft, rgt);
						y = $urandom_range(top_r, bot_r < heff ? bot_r : heff - 1);
					end
				endcase
				if ($urandom_range(0, 3) == 0)
					p = $urandom_range(0, 1) ? 255 : 0;
				else
					p = $urandom_range(0, 255);
				send_pixel(x, y, p);
			end
		end

		pix_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("[pixel_fade_to_white] OK");
		else
			$display("[pixel_fade_to_white] ERROR");
		$finish;
	end

endmodule

FILE: pixel_fade_to_white.f
hw/rtl/pfw_pkg.sv
hw/rtl/pfw_cfg.sv
hw/rtl/pfw_div_stage.sv
hw/rtl/pfw_blend.sv
hw/rtl/pixel_fade_to_white.sv
verif/pfw_fade_checker.sv
verif/tb_pixel_fade_to_white.sv
